// ===== rtl/fmqd_pkg.sv =====
// Package for the FM quadrature discriminator.
// Holds field widths, datapath widths, the arctangent table and the pipeline vector types.
// No dependencies.
package fmqd_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int PHASE_WIDTH   = 16;
    localparam int PROD_W        = 2 * SAMPLE_WIDTH;
    localparam int SUM_W         = PROD_W + 1;
    localparam int XY_W          = 50;
    localparam int Z_W           = 32;
    localparam int MAG_W         = 48;
    localparam int NORM_STAGES   = 6;
    localparam int ANG_TABLE_LEN = 24;

    localparam logic [SAMPLE_WIDTH-1:0] PREV_RESET = SAMPLE_WIDTH'(16384);
    localparam logic [Z_W-1:0]          ANG_PI     = {1'b1, {(Z_W-1){1'b0}}};
    localparam logic [Z_W-1:0]          Z_ROUND    = Z_W'(1) << (Z_W - PHASE_WIDTH - 1);

    typedef struct packed {
        logic             zero;
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
        logic [Z_W-1:0]   z;
    } cordic_vec_t;

    typedef struct packed {
        cordic_vec_t      v;
        logic [MAG_W-1:0] mag;
    } norm_vec_t;

    // atan(2^-k), 2^31 per pi
    function automatic logic [Z_W-1:0] atan_unit(input int k);
        logic [Z_W-1:0] a;
        unique case (k)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/fmqd_if.sv =====
// Channel interfaces for the FM quadrature discriminator: sample in, phase step out.
// Valid/ready handshake; depends on fmqd_pkg.
interface fmqd_sample_if
    import fmqd_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_i;
    logic signed [SAMPLE_WIDTH-1:0] in_q;

    modport source (output valid, output in_i, output in_q, input ready);
    modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

interface fmqd_result_if
    import fmqd_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [PHASE_WIDTH-1:0] phase_step;

    modport source (output valid, output phase_step, input ready);
    modport sink   (input valid, input phase_step, output ready);
endinterface

// ===== rtl/fmqd_norm_cell.sv =====
// Normalization cell: shifts the vector left by SHIFT when the larger magnitude stays below 2^47.
// Depends on fmqd_pkg.
module fmqd_norm_cell
    import fmqd_pkg::*;
#(
    parameter int SHIFT = 1
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  norm_vec_t in_vec,
    input  logic      down_hold,
    output logic      out_valid,
    output norm_vec_t out_vec,
    output logic      hold
);

    logic      valid_reg;
    norm_vec_t vec_reg;
    norm_vec_t vec_next;
    logic      fits;

    assign fits = (in_vec.mag[MAG_W-1 -: SHIFT+1] == '0);

    always_comb
    begin
        vec_next = in_vec;
        if (fits)
        begin
            vec_next.v.x = in_vec.v.x << SHIFT;
            vec_next.v.y = in_vec.v.y << SHIFT;
            vec_next.mag = in_vec.mag << SHIFT;
        end
    end

    assign hold = valid_reg & down_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/fmqd_cordic_cell.sv =====
// CORDIC vectoring cell for step K: rotates toward the x axis and accumulates the angle.
// Depends on fmqd_pkg.
module fmqd_cordic_cell
    import fmqd_pkg::*;
#(
    parameter int K = 0
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cordic_vec_t in_vec,
    input  logic        down_hold,
    output logic        out_valid,
    output cordic_vec_t out_vec,
    output logic        hold
);

    localparam logic [Z_W-1:0] ANGLE = atan_unit(K);

    logic               valid_reg;
    cordic_vec_t        vec_reg;
    cordic_vec_t        vec_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic               y_pos;

    assign dx    = $signed(in_vec.y) >>> K;
    assign dy    = $signed(in_vec.x) >>> K;
    assign y_pos = ~in_vec.y[XY_W-1] & (|in_vec.y);

    always_comb
    begin
        vec_next.zero = in_vec.zero;
        if (y_pos)
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ANGLE;
        end
        else
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ANGLE;
        end
    end

    assign hold = valid_reg & down_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/fm_quadrature_discriminator.sv =====
// Top level of the FM quadrature discriminator: cur * conj(prev), normalization, CORDIC atan2.
// Depends on fmqd_pkg, fmqd_if, fmqd_norm_cell, fmqd_cordic_cell.
//
//  channel  | dir | payload                 | handshake
//  ---------+-----+-------------------------+------------
//  sample   | in  | in_i, in_q (s16 each)   | valid/ready
//  result   | out | phase_step (s16)        | valid/ready
//
// Pipeline stages: products, sums, sign fold, six normalization cells,
// one CORDIC cell per step, output register.
// One item per cycle enters the cell chain while ready is high; empty cells close up while the output waits.
// Ready drops only when every cell holds an item and the result is not taken.
// Reset empties the chain and sets the stored sample to (16384, 16384).
module fm_quadrature_discriminator
    import fmqd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    fmqd_sample_if.sink   sample,
    fmqd_result_if.source result
);

    logic [SAMPLE_WIDTH-1:0] prev_i_reg;
    logic [SAMPLE_WIDTH-1:0] prev_q_reg;

    logic              accept;
    logic              in_zero;

    logic              s1_valid_reg;
    logic              s1_zero_reg;
    logic              s1_hold;
    logic [PROD_W-1:0] p_ii_reg;
    logic [PROD_W-1:0] p_qq_reg;
    logic [PROD_W-1:0] p_qi_reg;
    logic [PROD_W-1:0] p_iq_reg;

    logic              s2_valid_reg;
    logic              s2_zero_reg;
    logic              s2_hold;
    logic [SUM_W-1:0]  re_reg;
    logic [SUM_W-1:0]  im_reg;

    logic              re_neg;
    logic [SUM_W-1:0]  abs_re;
    logic [SUM_W-1:0]  abs_im;
    logic [SUM_W-1:0]  y_fold;
    norm_vec_t         nv_next;

    logic              nv_valid [0:NORM_STAGES];
    norm_vec_t         nv       [0:NORM_STAGES];
    logic              nv_hold  [0:NORM_STAGES+1];

    logic              cv_valid [0:CORDIC_STEPS];
    cordic_vec_t       cv       [0:CORDIC_STEPS];
    logic              cv_hold  [0:CORDIC_STEPS+1];

    logic              nv0_valid_reg;
    norm_vec_t         nv0_reg;

    logic                   out_valid_reg;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic                   out_hold;
    logic [Z_W-1:0]         z_round;

    // input, stored sample, products
    assign in_zero      = (sample.in_i == '0) && (sample.in_q == '0);
    assign sample.ready = ~s1_hold;
    assign accept       = sample.valid & ~s1_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_i_reg <= PREV_RESET;
            prev_q_reg <= PREV_RESET;
        end
        else if (accept && !in_zero)
        begin
            prev_i_reg <= sample.in_i;
            prev_q_reg <= sample.in_q;
        end
    end

    assign s1_hold = s1_valid_reg & s2_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_hold)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_zero_reg <= in_zero;
            p_ii_reg    <= PROD_W'($signed(sample.in_i) * $signed(prev_i_reg));
            p_qq_reg    <= PROD_W'($signed(sample.in_q) * $signed(prev_q_reg));
            p_qi_reg    <= PROD_W'($signed(sample.in_q) * $signed(prev_i_reg));
            p_iq_reg    <= PROD_W'($signed(sample.in_i) * $signed(prev_q_reg));
        end
    end

    // real and imaginary parts
    assign s2_hold = s2_valid_reg & nv_hold[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_hold)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s2_hold && s1_valid_reg)
        begin
            s2_zero_reg <= s1_zero_reg;
            re_reg      <= {p_ii_reg[PROD_W-1], p_ii_reg} + {p_qq_reg[PROD_W-1], p_qq_reg};
            im_reg      <= {p_qi_reg[PROD_W-1], p_qi_reg} - {p_iq_reg[PROD_W-1], p_iq_reg};
        end
    end

    // fold into the right half plane, magnitude for normalization
    assign re_neg = re_reg[SUM_W-1];
    assign abs_re = re_neg ? -re_reg : re_reg;
    assign abs_im = im_reg[SUM_W-1] ? -im_reg : im_reg;
    assign y_fold = re_neg ? -im_reg : im_reg;

    always_comb
    begin
        nv_next.v.zero = s2_zero_reg;
        nv_next.v.x    = {{(XY_W-SUM_W){abs_re[SUM_W-1]}}, abs_re};
        nv_next.v.y    = {{(XY_W-SUM_W){y_fold[SUM_W-1]}}, y_fold};
        nv_next.v.z    = re_neg ? ANG_PI : '0;
        nv_next.mag    = (abs_re > abs_im) ? {{(MAG_W-SUM_W){1'b0}}, abs_re}
                                           : {{(MAG_W-SUM_W){1'b0}}, abs_im};
    end

    assign nv_hold[0] = nv0_valid_reg & nv_hold[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv0_valid_reg <= 1'b0;
        end
        else if (!nv_hold[0])
        begin
            nv0_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!nv_hold[0] && s2_valid_reg)
        begin
            nv0_reg <= nv_next;
        end
    end

    assign nv_valid[0] = nv0_valid_reg;
    assign nv[0]       = nv0_reg;

    // normalization cells: shifts of 32, 16, 8, 4, 2, 1
    for (genvar j = 0; j < NORM_STAGES; j++)
    begin : g_norm
        fmqd_norm_cell #(
            .SHIFT (1 << (NORM_STAGES - 1 - j))
        ) u_norm (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (nv_valid[j]),
            .in_vec    (nv[j]),
            .down_hold (nv_hold[j+2]),
            .out_valid (nv_valid[j+1]),
            .out_vec   (nv[j+1]),
            .hold      (nv_hold[j+1])
        );
    end

    assign nv_hold[NORM_STAGES+1] = cv_hold[1];

    assign cv_valid[0] = nv_valid[NORM_STAGES];
    assign cv[0]       = nv[NORM_STAGES].v;
    assign cv_hold[0]  = nv_hold[NORM_STAGES];

    // CORDIC cells
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        fmqd_cordic_cell #(
            .K (k)
        ) u_cordic (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv_valid[k]),
            .in_vec    (cv[k]),
            .down_hold (cv_hold[k+2]),
            .out_valid (cv_valid[k+1]),
            .out_vec   (cv[k+1]),
            .hold      (cv_hold[k+1])
        );
    end

    // output register, round to nearest
    assign out_hold                = out_valid_reg & ~result.ready;
    assign cv_hold[CORDIC_STEPS+1] = out_hold;
    assign z_round                 = cv[CORDIC_STEPS].z + Z_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_hold)
        begin
            out_valid_reg <= cv_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_hold && cv_valid[CORDIC_STEPS])
        begin
            phase_reg <= cv[CORDIC_STEPS].zero ? '0 : z_round[Z_W-1 -: PHASE_WIDTH];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.phase_step = phase_reg;

`ifndef ASSERT_OFF
    a_prev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_i_reg != '0) || (prev_q_reg != '0))
        else $error("stored sample is zero");

    a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_zero) |=> (prev_i_reg == $past(sample.in_i))
                                 && (prev_q_reg == $past(sample.in_q)))
        else $error("stored sample not updated");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (out_valid_reg && !result.ready))
        else $error("input stalled without an output stall");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nv_valid[NORM_STAGES] && !nv[NORM_STAGES].v.zero)
            |-> (nv[NORM_STAGES].mag[MAG_W-1 -: 2] == 2'b01))
        else $error("vector not normalized");
`endif

endmodule

// ===== tb/tb_fm_quadrature_discriminator.sv =====
`timescale 1ns / 1ps
// Testbench for fm_quadrature_discriminator: drives I/Q samples and checks each phase step
// against an in-bench model of cur * conj(prev) and a CORDIC atan2.
// Depends on fmqd_pkg, fmqd_if and the RTL of the block.
module tb_fm_quadrature_discriminator;
    import fmqd_pkg::*;

    localparam int  STEPS      = 16;
    localparam real PI_R       = 3.14159265358979;
    localparam int  ITEMS_EACH = 320;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] i;
        logic signed [SAMPLE_WIDTH-1:0] q;
    } iq_t;

    logic clk;
    logic rst_n;

    fmqd_sample_if sample ();
    fmqd_result_if result ();

    fm_quadrature_discriminator #(.CORDIC_STEPS(STEPS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result)
    );

    iq_t                     pending_samples[$];
    logic [PHASE_WIDTH-1:0]  expected_steps[$];
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      errors;
    longint                  last_i;
    longint                  last_q;

    // atan(2^-k), 2^31 per pi
    longint atan_step [24] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [PHASE_WIDTH-1:0] vector_angle(input longint re, input longint im);
        longint x, y, z, dx, dy, a;
        int     k;
        x = re;
        y = im;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(1) <<< 31;
        end
        while (magnitude(x) < (longint'(1) <<< 46) && magnitude(y) < (longint'(1) <<< 46))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (k = 0; k < STEPS; k++)
        begin
            a  = (k < 24) ? atan_step[k] : 0;
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + a;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - a;
            end
        end
        z = (z + (longint'(1) <<< (31 - PHASE_WIDTH))) >>> (32 - PHASE_WIDTH);
        return z[PHASE_WIDTH-1:0];
    endfunction

    // updates the stored sample; a zero sample leaves it alone
    function automatic logic [PHASE_WIDTH-1:0] discriminate(input iq_t s);
        longint ci, cq, re, im;
        ci = longint'(s.i);
        cq = longint'(s.q);
        if (ci == 0 && cq == 0)
            return '0;
        re = ci * last_i + cq * last_q;
        im = cq * last_i - ci * last_q;
        last_i = ci;
        last_q = cq;
        if (re == 0 && im == 0)
            return '0;
        return vector_angle(re, im);
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid <= 1'b0;
            sample.in_i  <= '0;
            sample.in_q  <= '0;
            last_i = 16384;
            last_q = 16384;
        end
        else
        begin
            if (sample.valid && sample.ready)
                expected_steps.insert(expected_steps.size(),
                                      discriminate(iq_t'{sample.in_i, sample.in_q}));
            if (!sample.valid || sample.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample.in_i  <= pending_samples[0].i;
                    sample.in_q  <= pending_samples[0].q;
                    sample.valid <= 1'b1;
                    void'(pending_samples.pop_front());
                end
                else
                    sample.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("phase_step: unexpected item, expected none, actual %0d",
                           $signed(result.phase_step));
                    errors++;
                end
                else
                begin
                    if (result.phase_step !== expected_steps[0])
                    begin
                        $error("phase_step mismatch: expected %0d, actual %0d",
                               $signed(expected_steps[0]), $signed(result.phase_step));
                        errors++;
                    end
                    void'(expected_steps.pop_front());
                end
            end
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_sample(input int si, input int sq);
        pending_samples.insert(pending_samples.size(),
                               iq_t'{SAMPLE_WIDTH'(si), SAMPLE_WIDTH'(sq)});
    endtask

    function automatic int edge_or_random();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // mostly rotating phasors of random level and rate, the rest noise and phase jumps
    task automatic add_traffic(input int count);
        int  added, len, n, level_sel;
        real amp, ph, dph;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                level_sel = $urandom_range(2);
                if (level_sel == 0)
                    amp = real'($urandom_range(1, 15));
                else if (level_sel == 1)
                    amp = real'($urandom_range(16, 2000));
                else
                    amp = real'($urandom_range(2000, 32767));
                ph  = real'($urandom_range(65535)) / 32768.0 * PI_R;
                dph = (real'($urandom_range(65535)) - 32768.0) / 32768.0 * PI_R;
                if ($urandom_range(1) == 0)
                    dph = dph / 16.0;
                len = $urandom_range(8, 40);
                for (n = 0; n < len; n++)
                begin
                    if ($urandom_range(49) == 0)
                        add_sample(0, 0);
                    else
                        add_sample(int'(amp * $cos(ph)), int'(amp * $sin(ph)));
                    ph = ph + dph;
                end
                added += len;
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (n = 0; n < len; n++)
                    add_sample(edge_or_random(), edge_or_random());
                added += len;
            end
        end
    endtask

    task automatic wait_sent();
        while (pending_samples.size() != 0 || sample.valid)
            @(negedge clk);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        sample.valid   = 1'b0;
        sample.in_i    = '0;
        sample.in_q    = '0;
        result.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int drain;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        add_sample(16384, 16384);
        add_sample(-16384, -16384);
        add_sample(0, 0);
        add_sample(16384, -16384);
        add_sample(32767, 0);
        add_sample(-32768, 0);
        add_sample(0, 32767);
        add_sample(0, -32768);
        add_sample(-32768, -32768);
        add_sample(32767, 32767);
        add_sample(-32768, 32767);
        add_sample(32767, -32768);
        add_sample(1, 0);
        add_sample(-32768, 1);
        add_sample(-1, 0);
        add_sample(0, 1);
        add_sample(0, 0);
        add_sample(1, 1);
        add_sample(-1, -1);
        add_sample(32767, -1);
        add_sample(-32768, -1);
        add_sample(-1, -32768);
        add_traffic(ITEMS_EACH);
        wait_sent();

        @(negedge clk);
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        add_traffic(ITEMS_EACH);
        wait_sent();

        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        add_traffic(ITEMS_EACH);
        wait_sent();

        @(negedge clk);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        add_traffic(ITEMS_EACH);
        wait_sent();

        drain = 0;
        while (expected_steps.size() != 0 && drain < 100000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (40) @(negedge clk);
        if (expected_steps.size() != 0)
        begin
            $error("phase_step: %0d items never arrived, expected %0d, actual none",
                   expected_steps.size(), $signed(expected_steps[0]));
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fmqd_pkg.sv
rtl/fmqd_if.sv
rtl/fmqd_norm_cell.sv
rtl/fmqd_cordic_cell.sv
rtl/fm_quadrature_discriminator.sv
tb/tb_fm_quadrature_discriminator.sv
